FILE: hw/rtl/rtsw_pkg.sv
// ----------------------------------------------------------------------------
// rtsw_pkg
// Shared constants, command codes and status type for the rolling
// time-weighted speed window.
// ----------------------------------------------------------------------------
package rtsw_pkg;

    localparam int WINDOW_MS_DEF     = 4096;
    localparam int MAX_SAMPLE_MS_DEF = 1000;
    localparam int SLICE_DEPTH_DEF   = 4096;

    localparam int SPEED_W = 16;
    localparam int POWER_W = 12;
    localparam int DUR_W   = 16;
    localparam int LEN_W   = 13;
    localparam int OUT_W   = 13;
    // Speed times slice length; the window total always fits.
    localparam int SUM_W   = SPEED_W + LEN_W;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STEP_FILL,
        CMD_FRONT,
        CMD_SUB,
        CMD_PUSH,
        CMD_ADD,
        CMD_DIV_ROLL,
        CMD_DIV_BEST,
        CMD_DIV_STEP,
        CMD_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic run;
        logic rem_zero;
        logic filling;
        logic count_zero;
        logic take_zero;
        logic div_last;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/rtsw_datapath.sv
// ----------------------------------------------------------------------------
// rtsw_datapath
// Slice ring memories, window state, multiplier, serial divider and the
// result register.
// ----------------------------------------------------------------------------
module rtsw_datapath
    import rtsw_pkg::*;
#(
    parameter int WINDOW_MS     = WINDOW_MS_DEF,
    parameter int MAX_SAMPLE_MS = MAX_SAMPLE_MS_DEF,
    parameter int SLICE_DEPTH   = SLICE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 operation,
    input  logic [SPEED_W-1:0]   speed,
    input  logic [POWER_W-1:0]   actual_power,
    input  logic [POWER_W-1:0]   target_power,
    input  logic [DUR_W-1:0]     duration_ms,
    input  logic                 sample_invalid,
    input  logic                 result_stall,
    output logic                 result_valid,
    output logic [SPEED_W-1:0]   rolling_average,
    output logic [SPEED_W-1:0]   best_average,
    output logic [OUT_W-1:0]     filled_ms,
    output logic                 window_full,
    output logic [OUT_W-1:0]     power_hold_ms,
    output logic                 telemetry_valid
);

    localparam int FILL_W = $clog2(WINDOW_MS + 1);
    localparam int PTR_W  = $clog2(SLICE_DEPTH);
    localparam int CNT_W  = $clog2(SLICE_DEPTH + 1);
    localparam int IDX_W  = PTR_W + 1;
    localparam int DCNT_W = $clog2(SUM_W);
    // The best average divides by the fixed window length, so it uses a
    // rounded-up reciprocal that is exact for every dividend below 2^SUM_W.
    localparam int REC_L  = $clog2(WINDOW_MS);
    localparam int REC_SH = SUM_W + REC_L;
    localparam logic [SUM_W:0] BEST_RECIP =
        (SUM_W + 1)'((((64'd1 << REC_SH) + 64'(WINDOW_MS)) - 64'd1) / 64'(WINDOW_MS));

    logic [SPEED_W-1:0] spd_mem [SLICE_DEPTH];
    logic [LEN_W-1:0]   len_mem [SLICE_DEPTH];
    logic [SPEED_W-1:0] rd_spd_reg;
    logic [LEN_W-1:0]   rd_len_reg;

    logic [PTR_W-1:0]   oldest_reg, newest_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [FILL_W-1:0]  filled_reg, hold_reg;
    logic [SUM_W-1:0]   sum_reg, best_reg, prod_reg;
    logic               full_reg, valid_reg, fill_mode_reg;
    logic [DUR_W-1:0]   rem_reg;
    logic [SPEED_W-1:0] spd_reg, cache_spd_reg;
    logic [LEN_W-1:0]   cache_len_reg, take_reg;

    logic [SUM_W-1:0]   dq_reg;
    logic [FILL_W:0]    dr_reg;
    logic [FILL_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [SPEED_W-1:0] roll_q_reg, best_q_reg;

    logic [SPEED_W-1:0] rolling_reg, best_avg_reg;
    logic [OUT_W-1:0]   filled_out_reg, hold_out_reg;
    logic               full_out_reg, valid_out_reg, result_valid_reg;

    // Item decode
    logic in_range, sample_ok, clear_now;
    logic [DUR_W:0]     hold_sum;
    logic [FILL_W-1:0]  hold_next;

    always_comb
    begin
        in_range  = (duration_ms != '0) && (duration_ms <= DUR_W'(MAX_SAMPLE_MS));
        sample_ok = !sample_invalid && (target_power != '0);
        clear_now = operation || (in_range && !sample_ok);
        hold_sum  = (DUR_W + 1)'(hold_reg) + (DUR_W + 1)'(duration_ms);
        if (actual_power >= target_power)
        begin
            hold_next = (hold_sum < (DUR_W + 1)'(WINDOW_MS)) ?
                        FILL_W'(hold_sum) : FILL_W'(WINDOW_MS);
        end
        else
        begin
            hold_next = '0;
        end
    end

    // Take amounts
    logic [FILL_W-1:0] room;
    logic [LEN_W-1:0]  take_fill, take_front, front_left;

    always_comb
    begin
        room       = FILL_W'(WINDOW_MS) - filled_reg;
        take_fill  = ((DUR_W + 1)'(rem_reg) < (DUR_W + 1)'(room)) ?
                     LEN_W'(rem_reg) : LEN_W'(room);
        take_front = ((DUR_W + 1)'(rem_reg) < (DUR_W + 1)'(rd_len_reg)) ?
                     LEN_W'(rem_reg) : rd_len_reg;
        front_left = rd_len_reg - take_front;
    end

    // Ring pointers
    logic [IDX_W-1:0] idx_sum;
    logic [PTR_W-1:0] new_idx, oldest_inc;
    logic             merge;

    always_comb
    begin
        idx_sum = IDX_W'(oldest_reg) + IDX_W'(count_reg);
        if (idx_sum >= IDX_W'(SLICE_DEPTH))
        begin
            idx_sum = idx_sum - IDX_W'(SLICE_DEPTH);
        end
        new_idx    = idx_sum[PTR_W-1:0];
        oldest_inc = (oldest_reg == PTR_W'(SLICE_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
        merge      = (count_reg != '0) &&
                     ((cache_spd_reg == spd_reg) || (count_reg == CNT_W'(SLICE_DEPTH)));
    end

    // Sum update and best-window check
    logic [SUM_W-1:0]  sum_add;
    logic [FILL_W-1:0] filled_add;
    logic              take_best;

    always_comb
    begin
        sum_add    = sum_reg + prod_reg;
        filled_add = filled_reg + FILL_W'(take_reg);
        take_best  = !full_reg || (sum_add > best_reg);
    end

    // Best average by reciprocal multiplication
    logic [2*SUM_W:0]   best_prod;
    logic [SPEED_W-1:0] best_quot;

    always_comb
    begin
        best_prod = (2 * SUM_W + 1)'(best_reg) * (2 * SUM_W + 1)'(BEST_RECIP);
        best_quot = best_prod[REC_SH +: SPEED_W];
    end

    // Divider step, one quotient bit a cycle
    logic [FILL_W:0]  r_sh, r_new;
    logic             q_bit;
    logic [SUM_W-1:0] q_new;

    always_comb
    begin
        r_sh  = {dr_reg[FILL_W-1:0], dq_reg[SUM_W-1]};
        q_bit = (r_sh >= {1'b0, dvs_reg});
        r_new = q_bit ? (r_sh - {1'b0, dvs_reg}) : r_sh;
        q_new = {dq_reg[SUM_W-2:0], q_bit};
    end

    // Memory write port
    logic               spd_we, len_we;
    logic [PTR_W-1:0]   wr_addr;
    logic [LEN_W-1:0]   len_wdata;

    always_comb
    begin
        spd_we    = 1'b0;
        len_we    = 1'b0;
        wr_addr   = newest_reg;
        len_wdata = cache_len_reg + take_reg;
        if (cmd == CMD_FRONT && rd_len_reg != '0)
        begin
            len_we    = 1'b1;
            wr_addr   = oldest_reg;
            len_wdata = front_left;
        end
        else if (cmd == CMD_PUSH)
        begin
            len_we = 1'b1;
            if (!merge)
            begin
                spd_we    = 1'b1;
                wr_addr   = new_idx;
                len_wdata = take_reg;
            end
        end
    end

    // The read port follows the oldest slice continuously.
    always_ff @(posedge clk)
    begin
        if (spd_we)
        begin
            spd_mem[wr_addr] <= spd_reg;
        end
        if (len_we)
        begin
            len_mem[wr_addr] <= len_wdata;
        end
        rd_spd_reg <= spd_mem[oldest_reg];
        rd_len_reg <= len_mem[oldest_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg       <= '0;
            newest_reg       <= '0;
            count_reg        <= '0;
            filled_reg       <= '0;
            hold_reg         <= '0;
            sum_reg          <= '0;
            best_reg         <= '0;
            prod_reg         <= '0;
            full_reg         <= 1'b0;
            valid_reg        <= 1'b0;
            fill_mode_reg    <= 1'b0;
            rem_reg          <= '0;
            spd_reg          <= '0;
            cache_spd_reg    <= '0;
            cache_len_reg    <= '0;
            take_reg         <= '0;
            dq_reg           <= '0;
            dr_reg           <= '0;
            dvs_reg          <= '0;
            dcnt_reg         <= '0;
            roll_q_reg       <= '0;
            best_q_reg       <= '0;
            rolling_reg      <= '0;
            best_avg_reg     <= '0;
            filled_out_reg   <= '0;
            hold_out_reg     <= '0;
            full_out_reg     <= 1'b0;
            valid_out_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && cmd != CMD_OUT)
            begin
                result_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_LOAD:
                begin
                    if (operation || in_range)
                    begin
                        valid_reg <= !operation && sample_ok;
                    end
                    if (clear_now)
                    begin
                        oldest_reg <= '0;
                        newest_reg <= '0;
                        count_reg  <= '0;
                        filled_reg <= '0;
                        sum_reg    <= '0;
                        best_reg   <= '0;
                        full_reg   <= 1'b0;
                        hold_reg   <= '0;
                    end
                    else if (in_range)
                    begin
                        rem_reg  <= duration_ms;
                        spd_reg  <= speed;
                        hold_reg <= hold_next;
                    end
                end
                CMD_STEP_FILL:
                begin
                    take_reg      <= take_fill;
                    fill_mode_reg <= 1'b1;
                end
                CMD_FRONT:
                begin
                    if (rd_len_reg != '0)
                    begin
                        take_reg      <= take_front;
                        fill_mode_reg <= 1'b0;
                        prod_reg      <= SUM_W'(rd_spd_reg * take_front);
                        if (oldest_reg == newest_reg)
                        begin
                            cache_len_reg <= front_left;
                        end
                        if (front_left == '0)
                        begin
                            oldest_reg <= oldest_inc;
                            count_reg  <= count_reg - 1'b1;
                        end
                    end
                end
                CMD_SUB:
                begin
                    sum_reg <= sum_reg - prod_reg;
                end
                CMD_PUSH:
                begin
                    if (merge)
                    begin
                        cache_len_reg <= cache_len_reg + take_reg;
                        prod_reg      <= SUM_W'(cache_spd_reg * take_reg);
                    end
                    else
                    begin
                        newest_reg    <= new_idx;
                        cache_spd_reg <= spd_reg;
                        cache_len_reg <= take_reg;
                        count_reg     <= count_reg + 1'b1;
                        prod_reg      <= SUM_W'(spd_reg * take_reg);
                    end
                end
                CMD_ADD:
                begin
                    sum_reg <= sum_add;
                    rem_reg <= rem_reg - DUR_W'(take_reg);
                    if (fill_mode_reg)
                    begin
                        filled_reg <= filled_add;
                    end
                    // Filling notes the window only when it just became full.
                    if (!fill_mode_reg || filled_add == FILL_W'(WINDOW_MS))
                    begin
                        if (take_best)
                        begin
                            best_reg <= sum_add;
                        end
                        full_reg <= 1'b1;
                    end
                end
                CMD_DIV_ROLL:
                begin
                    dq_reg   <= sum_reg;
                    dr_reg   <= '0;
                    dvs_reg  <= filled_reg;
                    dcnt_reg <= '0;
                end
                CMD_DIV_BEST:
                begin
                    best_q_reg <= best_quot;
                end
                CMD_DIV_STEP:
                begin
                    dq_reg   <= q_new;
                    dr_reg   <= r_new;
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (status.div_last)
                    begin
                        roll_q_reg <= (dvs_reg == '0) ? '0 : q_new[SPEED_W-1:0];
                    end
                end
                CMD_OUT:
                begin
                    rolling_reg      <= roll_q_reg;
                    best_avg_reg     <= best_q_reg;
                    filled_out_reg   <= OUT_W'(filled_reg);
                    hold_out_reg     <= OUT_W'(hold_reg);
                    full_out_reg     <= full_reg;
                    valid_out_reg    <= valid_reg;
                    result_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        status.run        = !operation && in_range && sample_ok;
        status.rem_zero   = (rem_reg == '0);
        status.filling    = (filled_reg < FILL_W'(WINDOW_MS));
        status.count_zero = (count_reg == '0);
        status.take_zero  = (rd_len_reg == '0);
        status.div_last   = (dcnt_reg == DCNT_W'(SUM_W - 1));
        status.out_busy   = result_valid_reg && result_stall;
    end

    assign result_valid    = result_valid_reg;
    assign rolling_average = rolling_reg;
    assign best_average    = best_avg_reg;
    assign filled_ms       = filled_out_reg;
    assign window_full     = full_out_reg;
    assign power_hold_ms   = hold_out_reg;
    assign telemetry_valid = valid_out_reg;

endmodule

FILE: hw/rtl/rtsw_ctrl.sv
// ----------------------------------------------------------------------------
// rtsw_ctrl
// Sequencer that walks one sample through fill, front replacement,
// division and result hand-off.
// ----------------------------------------------------------------------------
module rtsw_ctrl
    import rtsw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_FRONT,
        S_SUB,
        S_PUSH,
        S_ADD,
        S_DIVR,
        S_DIVR_RUN,
        S_DIVB,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = status.run ? S_LOOP : S_DIVR;
                end
            end
            S_LOOP:
            begin
                if (status.rem_zero)
                begin
                    state_next = S_DIVR;
                end
                else if (status.filling)
                begin
                    cmd        = CMD_STEP_FILL;
                    state_next = S_PUSH;
                end
                else if (status.count_zero)
                begin
                    state_next = S_DIVR;
                end
                else
                begin
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                cmd        = CMD_FRONT;
                state_next = status.take_zero ? S_DIVR : S_SUB;
            end
            S_SUB:
            begin
                cmd        = CMD_SUB;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd        = CMD_PUSH;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd        = CMD_ADD;
                state_next = S_LOOP;
            end
            S_DIVR:
            begin
                cmd        = CMD_DIV_ROLL;
                state_next = S_DIVR_RUN;
            end
            S_DIVR_RUN:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_DIVB;
                end
            end
            S_DIVB:
            begin
                cmd        = CMD_DIV_BEST;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd        = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign sample_stall = (state_reg != S_IDLE);

endmodule

FILE: hw/rtl/rolling_time_weighted_speed_window.sv
// ----------------------------------------------------------------------------
// rolling_time_weighted_speed_window
// Time-weighted moving speed average over a window of milliseconds, with a
// best-window hold and a power hold timer.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A clear, an ignored sample or an invalid one
// passes through the accepting state, the start of the rolling division, 29
// serial division steps, the best average (a multiplication by the
// reciprocal of the window length) and the load of the result register. A
// sample that is added also passes through a final loop check, through a loop
// check, push and add if part of it goes into a window that is still filling,
// and through a loop check, front read, subtract, push and add for every front
// slice that its time eats into, so a long sample over many 1 ms slices walks
// through many such rounds. The result sits in an output register, so the
// next sample is taken while it waits; a result that is still stalled when
// the next one is ready holds the block in its output state.
module rolling_time_weighted_speed_window
    import rtsw_pkg::*;
#(
    parameter int WINDOW_MS     = WINDOW_MS_DEF,
    parameter int MAX_SAMPLE_MS = MAX_SAMPLE_MS_DEF,
    parameter int SLICE_DEPTH   = SLICE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic               operation,
    input  logic [SPEED_W-1:0] speed,
    input  logic [POWER_W-1:0] actual_power,
    input  logic [POWER_W-1:0] target_power,
    input  logic [DUR_W-1:0]   duration_ms,
    input  logic               sample_invalid,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [SPEED_W-1:0] rolling_average,
    output logic [SPEED_W-1:0] best_average,
    output logic [OUT_W-1:0]   filled_ms,
    output logic               window_full,
    output logic [OUT_W-1:0]   power_hold_ms,
    output logic               telemetry_valid
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rtsw_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    rtsw_datapath
    #(
        .WINDOW_MS     (WINDOW_MS),
        .MAX_SAMPLE_MS (MAX_SAMPLE_MS),
        .SLICE_DEPTH   (SLICE_DEPTH)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (operation),
        .speed           (speed),
        .actual_power    (actual_power),
        .target_power    (target_power),
        .duration_ms     (duration_ms),
        .sample_invalid  (sample_invalid),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .rolling_average (rolling_average),
        .best_average    (best_average),
        .filled_ms       (filled_ms),
        .window_full     (window_full),
        .power_hold_ms   (power_hold_ms),
        .telemetry_valid (telemetry_valid)
    );

endmodule

FILE: tb/sv/tb_rolling_time_weighted_speed_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rolling_time_weighted_speed_window
// Drives speed samples and clears into the rolling window, predicts every
// status result with a behavioural slice ring and checks each transfer in
// order, with random gaps on the sample side and random stalls on the result
// side.
// ----------------------------------------------------------------------------
module tb_rolling_time_weighted_speed_window;
    import rtsw_pkg::*;

    localparam int WIN   = WINDOW_MS_DEF;
    localparam int MAXMS = MAX_SAMPLE_MS_DEF;
    localparam int DEPTH = SLICE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [SPEED_W-1:0] rolling;
        logic [SPEED_W-1:0] best;
        logic [OUT_W-1:0]   filled;
        logic               full;
        logic [OUT_W-1:0]   hold;
        logic               tvalid;
    } status_t;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    logic operation;
    logic [SPEED_W-1:0] speed;
    logic [POWER_W-1:0] actual_power;
    logic [POWER_W-1:0] target_power;
    logic [DUR_W-1:0] duration_ms;
    logic sample_invalid;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [SPEED_W-1:0] rolling_average;
    logic [SPEED_W-1:0] best_average;
    logic [OUT_W-1:0] filled_ms;
    logic window_full;
    logic [OUT_W-1:0] power_hold_ms;
    logic telemetry_valid;

    rolling_time_weighted_speed_window u_dut (.*);

    // Predicted window state.
    logic [15:0] ring_speed [DEPTH];
    int unsigned ring_len [DEPTH];
    int unsigned head_idx, tail_idx, n_slices, time_held, hold_acc;
    longint unsigned sum_now, sum_best;
    bit seen_full, tel_ok;

    status_t expected_status[$];
    bit failed = 1'b0;
    int idle_cycles = 0;
    int burst_left;
    int stall_mode = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void exp_put(status_t s);
        expected_status.insert(expected_status.size(), s);
    endfunction

    function automatic status_t exp_take();
        status_t s;
        s = expected_status[0];
        expected_status.delete(0);
        return s;
    endfunction

    function automatic void wipe_window();
        head_idx = 0; tail_idx = 0; n_slices = 0; time_held = 0;
        sum_now = 0; sum_best = 0; seen_full = 0; hold_acc = 0;
    endfunction

    function automatic int unsigned append_time(int unsigned spd, int unsigned ms);
        if (n_slices > 0 && (ring_speed[tail_idx] == spd || n_slices >= DEPTH)) begin
            ring_len[tail_idx] = (ring_len[tail_idx] + ms) & 16'h1FFF;
            return ring_speed[tail_idx];
        end
        tail_idx = (head_idx + n_slices) % DEPTH;
        ring_speed[tail_idx] = spd;
        ring_len[tail_idx] = ms;
        n_slices++;
        return spd;
    endfunction

    function automatic void record_full();
        if (!seen_full || sum_now > sum_best)
            sum_best = sum_now;
        seen_full = 1;
    endfunction

    function automatic void advance_window(int unsigned spd, int unsigned dur);
        int unsigned left, take, used, flen;
        left = dur;
        while (left > 0) begin
            if (time_held < WIN) begin
                take = (left < WIN - time_held) ? left : WIN - time_held;
                used = append_time(spd, take);
                sum_now += used * take;
                time_held += take;
                left -= take;
                if (time_held == WIN)
                    record_full();
            end
            else begin
                if (n_slices == 0)
                    break;
                flen = ring_len[head_idx];
                take = (left < flen) ? left : flen;
                if (take == 0)
                    break;
                flen -= take;
                ring_len[head_idx] = flen;
                sum_now -= ring_speed[head_idx] * take;
                if (flen == 0) begin
                    head_idx = (head_idx + 1) % DEPTH;
                    n_slices--;
                end
                used = append_time(spd, take);
                sum_now += used * take;
                left -= take;
                record_full();
            end
        end
    endfunction

    function automatic status_t predict_status(logic op, int unsigned spd, int unsigned act,
                                               int unsigned tgt, int unsigned dur, logic bad);
        status_t s;
        if (op == OP_CLEAR) begin
            wipe_window();
            tel_ok = 0;
        end
        else if (dur != 0 && dur <= MAXMS) begin
            tel_ok = (bad == 0 && tgt != 0);
            if (!tel_ok)
                wipe_window();
            else begin
                advance_window(spd, dur);
                if (act >= tgt)
                    hold_acc = (hold_acc + dur < WIN) ? hold_acc + dur : WIN;
                else
                    hold_acc = 0;
            end
        end
        s.rolling = (time_held == 0) ? '0 : SPEED_W'(sum_now / time_held);
        s.best = SPEED_W'(sum_best / WIN);
        s.filled = OUT_W'(time_held);
        s.full = seen_full;
        s.hold = OUT_W'(hold_acc);
        s.tvalid = tel_ok;
        return s;
    endfunction

    task automatic send_sample(logic op, int unsigned spd, int unsigned act,
                               int unsigned tgt, int unsigned dur, logic bad);
        int gap;
        logic [SPEED_W-1:0] spd_f;
        logic [POWER_W-1:0] act_f, tgt_f;
        logic [DUR_W-1:0]   dur_f;
        // The port widths cut the values, and the prediction uses the same bits.
        spd_f = SPEED_W'(spd);
        act_f = POWER_W'(act);
        tgt_f = POWER_W'(tgt);
        dur_f = DUR_W'(dur);
        // Random gaps between bursts of back-to-back transfers.
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40)) : 0;
            if (gap > 0) begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        sample_valid <= 1'b1;
        operation <= op;
        speed <= spd_f;
        actual_power <= act_f;
        target_power <= tgt_f;
        duration_ms <= dur_f;
        sample_invalid <= bad;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        exp_put(predict_status(op, 32'(spd_f), 32'(act_f), 32'(tgt_f), 32'(dur_f), bad));
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
    endtask

    task automatic add_sample(int unsigned spd, int unsigned dur, int unsigned act = 200,
                              int unsigned tgt = 100);
        send_sample(OP_ADD, spd, act, tgt, dur, 1'b0);
    endtask

    task automatic test_directed_extremes();
        add_sample(16'hFFFF, MAXMS);
        add_sample(0, 1);
        add_sample(1234, 0);
        add_sample(1234, MAXMS + 1);
        add_sample(1234, 16'hFFFF);
        add_sample(16'hFFFF, MAXMS, 12'hFFF, 12'hFFF);
        add_sample(16'hFFFF, MAXMS, 0, 1);
        add_sample(16'hFFFF, MAXMS, 12'hFFF, 1);
        add_sample(16'hFFFF, MAXMS, 12'hFFF, 1);
        add_sample(16'hFFFF, MAXMS, 12'hFFF, 1);
        add_sample(500, MAXMS, 12'hFFF, 1);
        send_sample(OP_CLEAR, 16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_merge_and_replace();
        // Equal speeds merge; a later faster run displaces the oldest slices.
        repeat (6) add_sample(300, 700);
        repeat (8) add_sample(900, $urandom_range(1, MAXMS));
        add_sample(900, 5, 100, 0);
        add_sample(900, 5);
        send_sample(OP_ADD, 800, 100, 100, 100, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_sequences();
        int unsigned spd, dur, act, tgt;
        logic bad;
        for (int i = 0; i < 1520; i++) begin
            if (i == 760)
                wait_drained();
            case ($urandom_range(0, 19))
                0: send_sample(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                               1'($urandom));
                1: add_sample($urandom, $urandom_range(0, 1) ? 0 : $urandom_range(MAXMS + 1,
                              16'hFFFF));
                2: send_sample(OP_ADD, $urandom, $urandom, $urandom_range(0, 1) ? 0 :
                               $urandom, $urandom_range(1, MAXMS), 1'($urandom_range(0, 1)));
                default: begin
                    // Few distinct speeds give merges; short durations give many slices.
                    spd = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 7) * 9000;
                    dur = $urandom_range(0, 1) ? $urandom_range(1, 40) :
                          $urandom_range(1, MAXMS);
                    tgt = $urandom_range(1, 12'hFFF);
                    act = $urandom_range(0, 3) == 0 ? $urandom : tgt + $urandom_range(0, 5);
                    bad = 1'b0;
                    send_sample(OP_ADD, spd, act & 12'hFFF, tgt, dur, bad);
                end
            endcase
        end
        wait_drained();
    endtask

    // Result checker.
    always @(posedge clk) begin
        status_t got, exp_s;
        if (rst_n && result_valid && !result_stall) begin
            got = '{rolling_average, best_average, filled_ms, window_full,
                    power_hold_ms, telemetry_valid};
            if (expected_status.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                failed = 1;
            end
            else begin
                exp_s = exp_take();
                if (got !== exp_s) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_s, got);
                    failed = 1;
                end
            end
        end
    end

    // Receiver stalls on its own pattern, with stall-free stretches.
    always @(posedge clk) begin
        if (($urandom & 255) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            default: result_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge clk) begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        burst_left = 0;
        wipe_window(); tel_ok = 0;
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        operation <= OP_ADD; speed <= '0; actual_power <= '0; target_power <= '0;
        duration_ms <= '0; sample_invalid <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_merge_and_replace();
        test_random_sequences();
        repeat (200) @(posedge clk);
        if (!failed && expected_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
